/* rtl/core/pcr_pkg.sv */
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants of the parallel copy resolver.
// ----------------------------------------------------------------------------
package pcr_pkg;

	localparam int MAX_REGS_DEF = 16;

	localparam int REG_W  = 4;
	localparam int SLOT_W = 4;
	localparam int KIND_W = 2;
	localparam int CFG_W  = 5;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX     = 5'd31;
	localparam logic [CFG_W-1:0] REG_COUNT_RST = 5'd16;

	localparam logic [KIND_W-1:0] KIND_PERM    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_ONE
	} cnt_op_t;

	typedef struct packed {
		logic push;
		logic clear;
	} rb_ctrl_t;

endpackage

/* rtl/core/parallel_copy_resolver_top.sv */
// Load beat: each move is a table write, then a live-source fixup; ready only when idle.
// Final beat with a real move: a keep pass, a scan of each destination with an inner
// pass per kept source edge, a permutation walk, the restore copies, one end beat; output
// stalls hold up the last three. Final beat with no real move: goes to the end marker.
// Reset is asynchronous: tables empty, counts zero, reg_count 16, no beat pending.
// ----------------------------------------------------------------------------
// parallel_copy_resolver_top
// Parallel copy resolver: collects a move set, emits permutation moves,
// restore copies and an end marker.
// ----------------------------------------------------------------------------
module parallel_copy_resolver_top #(
	parameter int MAX_REGS = pcr_pkg::MAX_REGS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcr_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pcr_pkg::REG_W-1:0]     dest_reg,
	input  logic [pcr_pkg::REG_W-1:0]     src_reg,
	input  logic                          src_live,
	input  logic                          last_move,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pcr_pkg::KIND_W-1:0]    kind,
	output logic [pcr_pkg::REG_W-1:0]     move_from,
	output logic [pcr_pkg::REG_W-1:0]     move_to,
	output logic [pcr_pkg::SLOT_W-1:0]    perm_slot,
	output logic                          last_result
);
	import pcr_pkg::*;

	localparam int IW = $clog2(MAX_REGS);
	localparam int NW = $clog2(MAX_REGS + 1);
	localparam int CW = (NW > CFG_W) ? NW : CFG_W;

	logic [CFG_W-1:0] reg_count_q;
	logic [NW-1:0]    n;
	rb_ctrl_t         rb_ctrl;
	logic [IW-1:0]    rb_hi;
	logic [IW-1:0]    rb_lo;
	logic [IW-1:0]    rb_rd_idx;
	logic [IW-1:0]    rb_rd_hi;
	logic [IW-1:0]    rb_rd_lo;
	logic [NW-1:0]    rb_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_count_q <= REG_COUNT_RST;
		end else if (cfg_we) begin
			reg_count_q <= cfg_wdata;
		end
	end

	// clamp to 1..MAX_REGS
	always_comb begin
		if (reg_count_q == '0) begin
			n = NW'(1);
		end else if (CW'(reg_count_q) > CW'(MAX_REGS)) begin
			n = NW'(MAX_REGS);
		end else begin
			n = NW'(reg_count_q);
		end
	end

	pcr_core #(
		.MAX_REGS(MAX_REGS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.n          (n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.dest_reg   (dest_reg),
		.src_reg    (src_reg),
		.src_live   (src_live),
		.last_move  (last_move),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.move_from  (move_from),
		.move_to    (move_to),
		.perm_slot  (perm_slot),
		.last_result(last_result),
		.rb_ctrl    (rb_ctrl),
		.rb_hi      (rb_hi),
		.rb_lo      (rb_lo),
		.rb_rd_idx  (rb_rd_idx),
		.rb_rd_hi   (rb_rd_hi),
		.rb_rd_lo   (rb_rd_lo),
		.rb_total   (rb_total)
	);

	pcr_rbuf #(
		.MAX_REGS(MAX_REGS)
	) u_rbuf (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (rb_ctrl),
		.wr_hi (rb_hi),
		.wr_lo (rb_lo),
		.rd_idx(rb_rd_idx),
		.rd_hi (rb_rd_hi),
		.rd_lo (rb_rd_lo),
		.total (rb_total)
	);

endmodule

/* rtl/core/pcr_unit.sv */
// ----------------------------------------------------------------------------
// pcr_unit
// Shared use-count update and register compare unit.
// ----------------------------------------------------------------------------
module pcr_unit #(
	parameter int MAX_REGS = pcr_pkg::MAX_REGS_DEF
) (
	input  pcr_pkg::cnt_op_t                     op,
	input  logic [pcr_pkg::CNT_W-1:0]            cnt,
	output logic [pcr_pkg::CNT_W-1:0]            cnt_nxt,
	output logic                                 is_one,
	input  logic [$clog2(MAX_REGS+1)-1:0]        cmp_a,
	input  logic [$clog2(MAX_REGS+1)-1:0]        cmp_b,
	output logic                                 eq
);
	import pcr_pkg::*;

	always_comb begin
		case (op)
			CNT_INC: cnt_nxt = (cnt < COUNT_MAX) ? cnt + CNT_W'(1) : cnt;
			CNT_DEC: cnt_nxt = (cnt != '0) ? cnt - CNT_W'(1) : cnt;
			CNT_ONE: cnt_nxt = CNT_W'(1);
			default: cnt_nxt = cnt;
		endcase
	end

	assign is_one = (cnt == CNT_W'(1));
	assign eq     = (cmp_a == cmp_b);

endmodule

/* rtl/core/pcr_rbuf.sv */
// ----------------------------------------------------------------------------
// pcr_rbuf
// Restore copy list: appended during the scan, read back in order.
// ----------------------------------------------------------------------------
module pcr_rbuf #(
	parameter int MAX_REGS = pcr_pkg::MAX_REGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pcr_pkg::rb_ctrl_t               ctrl,
	input  logic [$clog2(MAX_REGS)-1:0]     wr_hi,
	input  logic [$clog2(MAX_REGS)-1:0]     wr_lo,
	input  logic [$clog2(MAX_REGS)-1:0]     rd_idx,
	output logic [$clog2(MAX_REGS)-1:0]     rd_hi,
	output logic [$clog2(MAX_REGS)-1:0]     rd_lo,
	output logic [$clog2(MAX_REGS+1)-1:0]   total
);
	import pcr_pkg::*;

	localparam int IW = $clog2(MAX_REGS);
	localparam int NW = $clog2(MAX_REGS + 1);

	logic [IW-1:0] hi_q [MAX_REGS];
	logic [IW-1:0] lo_q [MAX_REGS];
	logic [IW-1:0] rd_hi_q;
	logic [IW-1:0] rd_lo_q;
	logic [NW-1:0] total_q;
	logic          room;

	assign room = (total_q < NW'(MAX_REGS));

	// read data is registered: it lands in the cycle after rd_idx
	always_ff @(posedge clk) begin
		if (ctrl.push && room) begin
			hi_q[IW'(total_q)] <= wr_hi;
			lo_q[IW'(total_q)] <= wr_lo;
		end
		rd_hi_q <= hi_q[rd_idx];
		rd_lo_q <= lo_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.clear) begin
			total_q <= '0;
		end else if (ctrl.push && room) begin
			total_q <= total_q + NW'(1);
		end
	end

	assign rd_hi = rd_hi_q;
	assign rd_lo = rd_lo_q;
	assign total = total_q;

endmodule

/* rtl/core/pcr_core.sv */
// ----------------------------------------------------------------------------
// pcr_core
// Move table, use counts and the sequencer that loads, scans and emits.
// ----------------------------------------------------------------------------
module pcr_core #(
	parameter int MAX_REGS = pcr_pkg::MAX_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_REGS+1)-1:0]      n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [pcr_pkg::REG_W-1:0]          dest_reg,
	input  logic [pcr_pkg::REG_W-1:0]          src_reg,
	input  logic                               src_live,
	input  logic                               last_move,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pcr_pkg::KIND_W-1:0]         kind,
	output logic [pcr_pkg::REG_W-1:0]          move_from,
	output logic [pcr_pkg::REG_W-1:0]          move_to,
	output logic [pcr_pkg::SLOT_W-1:0]         perm_slot,
	output logic                               last_result,
	output pcr_pkg::rb_ctrl_t                  rb_ctrl,
	output logic [$clog2(MAX_REGS)-1:0]        rb_hi,
	output logic [$clog2(MAX_REGS)-1:0]        rb_lo,
	output logic [$clog2(MAX_REGS)-1:0]        rb_rd_idx,
	input  logic [$clog2(MAX_REGS)-1:0]        rb_rd_hi,
	input  logic [$clog2(MAX_REGS)-1:0]        rb_rd_lo,
	input  logic [$clog2(MAX_REGS+1)-1:0]      rb_total
);
	import pcr_pkg::*;

	localparam int IW = $clog2(MAX_REGS);
	localparam int NW = $clog2(MAX_REGS + 1);
	localparam int CW = (NW > REG_W) ? NW : REG_W;
	localparam logic [NW-1:0] NONE_REG = NW'(MAX_REGS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LIVE,
		S_KEEP,
		S_HEAD,
		S_INNER,
		S_PERM,
		S_REST,
		S_END
	} state_t;

	state_t                state_q;
	logic [NW-1:0]         st_q [MAX_REGS];
	logic [CNT_W-1:0]      uc_q [MAX_REGS];
	logic [MAX_REGS-1:0]   keep_q;
	logic                  need_q;
	logic [IW-1:0]         src_q;
	logic                  live_q;
	logic                  last_q;
	logic                  ok_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         to_q;
	logic [NW-1:0]         from_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [REG_W-1:0]      from_out_q;
	logic [REG_W-1:0]      to_out_q;
	logic [SLOT_W-1:0]     slot_out_q;
	logic                  last_out_q;

	logic [IW-1:0]         st_ra;
	logic [NW-1:0]         st_rd;
	logic [IW-1:0]         uc_addr;
	logic [CNT_W-1:0]      uc_rd;
	cnt_op_t               u_op;
	logic [CNT_W-1:0]      u_nxt;
	logic                  u_one;
	logic [NW-1:0]         cmp_b;
	logic                  u_eq;
	logic                  acc;
	logic                  in_ok;
	logic                  ld_ok;
	logic                  last_i;
	logic                  last_to;
	logic                  from_ok;
	logic                  perm_emit;
	logic                  out_load;

	always_comb begin
		st_ra   = (state_q == S_HEAD) ? to_q : idx_q;
		st_rd   = st_q[st_ra];
		uc_addr = idx_q;
		u_op    = CNT_HOLD;
		cmp_b   = from_q;
		case (state_q)
			S_IDLE: begin
				uc_addr = IW'(src_reg);
				u_op    = CNT_INC;
			end
			S_KEEP: begin
				u_op = CNT_INC;
			end
			S_HEAD: begin
				uc_addr = IW'(st_rd);
				u_op    = CNT_DEC;
				cmp_b   = NW'(to_q);
			end
			S_INNER: begin
				uc_addr = IW'(from_q);
				u_op    = CNT_ONE;
			end
			S_PERM: begin
				cmp_b = NW'(idx_q);
			end
			default: ;
		endcase
	end

	assign uc_rd = uc_q[uc_addr];

	pcr_unit #(
		.MAX_REGS(MAX_REGS)
	) u_unit (
		.op     (u_op),
		.cnt    (uc_rd),
		.cnt_nxt(u_nxt),
		.is_one (u_one),
		.cmp_a  (st_rd),
		.cmp_b  (cmp_b),
		.eq     (u_eq)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign in_ok     = (CW'(dest_reg) < CW'(n)) && (CW'(src_reg) < CW'(n));
	assign ld_ok     = !out_valid_q || out_ready;
	assign last_i    = (NW'(idx_q) == n - NW'(1));
	assign last_to   = (NW'(to_q) == n - NW'(1));
	assign from_ok   = (st_rd < n);
	assign perm_emit = from_ok && !u_eq;
	assign out_load  = ld_ok && (((state_q == S_PERM) && perm_emit)
		|| (state_q == S_REST) || (state_q == S_END));

	assign rb_ctrl.push  = (state_q == S_INNER) && (idx_q != to_q) && u_eq;
	assign rb_ctrl.clear = (state_q == S_END) && ld_ok;
	assign rb_hi         = to_q;
	assign rb_lo         = idx_q;
	// list read is registered: address the entry needed next cycle
	assign rb_rd_idx     = (state_q != S_REST) ? '0 :
		(ld_ok ? idx_q + IW'(1) : idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int k = 0; k < MAX_REGS; k++) begin
				st_q[k] <= NONE_REG;
				uc_q[k] <= '0;
			end
			keep_q      <= '0;
			need_q      <= 1'b0;
			src_q       <= '0;
			live_q      <= 1'b0;
			last_q      <= 1'b0;
			ok_q        <= 1'b0;
			idx_q       <= '0;
			to_q        <= '0;
			from_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_PERM;
			from_out_q  <= '0;
			to_out_q    <= '0;
			slot_out_q  <= '0;
			last_out_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						src_q  <= IW'(src_reg);
						live_q <= src_live;
						last_q <= last_move;
						ok_q   <= in_ok;
						if (in_ok) begin
							st_q[IW'(dest_reg)] <= NW'(src_reg);
							uc_q[uc_addr]       <= u_nxt;
							if (dest_reg != src_reg) begin
								need_q <= 1'b1;
							end
						end
						state_q <= S_LIVE;
					end
				end
				S_LIVE: begin
					if (ok_q && live_q) begin
						st_q[src_q]   <= NW'(src_q);
						keep_q[src_q] <= 1'b1;
					end
					idx_q <= '0;
					to_q  <= '0;
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (need_q) begin
						state_q <= S_KEEP;
					end else begin
						state_q <= S_END;
					end
				end
				S_KEEP: begin
					if (keep_q[idx_q]) begin
						uc_q[uc_addr] <= u_nxt;
					end
					if (last_i) begin
						state_q <= S_HEAD;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_HEAD: begin
					if (from_ok && (u_eq || u_one)) begin
						from_q  <= st_rd;
						idx_q   <= '0;
						state_q <= S_INNER;
					end else begin
						if (from_ok) begin
							uc_q[uc_addr] <= u_nxt;
						end
						if (last_to) begin
							idx_q   <= '0;
							slot_q  <= '0;
							state_q <= S_PERM;
						end else begin
							to_q <= to_q + IW'(1);
						end
					end
				end
				S_INNER: begin
					if (rb_ctrl.push) begin
						st_q[idx_q] <= NONE_REG;
					end
					if (last_i) begin
						uc_q[uc_addr] <= u_nxt;
						if (last_to) begin
							idx_q   <= '0;
							slot_q  <= '0;
							state_q <= S_PERM;
						end else begin
							to_q    <= to_q + IW'(1);
							state_q <= S_HEAD;
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_PERM: begin
					if (!perm_emit || ld_ok) begin
						if (perm_emit) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_PERM;
							from_out_q  <= REG_W'(st_rd);
							to_out_q    <= REG_W'(idx_q);
							slot_out_q  <= slot_q;
							last_out_q  <= 1'b0;
							slot_q      <= slot_q + SLOT_W'(1);
						end
						if (last_i) begin
							idx_q   <= '0;
							state_q <= (rb_total == '0) ? S_END : S_REST;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_REST: begin
					if (ld_ok) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_RESTORE;
						from_out_q  <= REG_W'(rb_rd_hi);
						to_out_q    <= REG_W'(rb_rd_lo);
						slot_out_q  <= '0;
						last_out_q  <= 1'b0;
						if (NW'(idx_q) + NW'(1) == rb_total) begin
							state_q <= S_END;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_END: begin
					if (ld_ok) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_END;
						from_out_q  <= '0;
						to_out_q    <= '0;
						slot_out_q  <= '0;
						last_out_q  <= 1'b1;
						for (int k = 0; k < MAX_REGS; k++) begin
							st_q[k] <= NONE_REG;
							uc_q[k] <= '0;
						end
						keep_q  <= '0;
						need_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign move_from   = from_out_q;
	assign move_to     = to_out_q;
	assign perm_slot   = slot_out_q;
	assign last_result = last_out_q;

endmodule

/* rtl/core/pcr_check.sv */
// ----------------------------------------------------------------------------
// pcr_check
// Port-level checks of the parallel copy resolver, bound to the top level.
// ----------------------------------------------------------------------------
module pcr_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [pcr_pkg::CFG_W-1:0]     cfg_wdata,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [pcr_pkg::REG_W-1:0]     dest_reg,
	input logic [pcr_pkg::REG_W-1:0]     src_reg,
	input logic                          src_live,
	input logic                          last_move,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pcr_pkg::KIND_W-1:0]    kind,
	input logic [pcr_pkg::REG_W-1:0]     move_from,
	input logic [pcr_pkg::REG_W-1:0]     move_to,
	input logic [pcr_pkg::SLOT_W-1:0]    perm_slot,
	input logic                          last_result
);
	import pcr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(move_from)
			&& $stable(move_to) && $stable(perm_slot) && $stable(last_result))
		else $error("result beat changed while stalled");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (kind == KIND_END)))
		else $error("last_result and end marker disagree");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> move_from == '0 && move_to == '0 && perm_slot == '0)
		else $error("end marker carries nonzero fields");

	a_restore_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_RESTORE |-> perm_slot == '0)
		else $error("restore copy carries a slot");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input beat taken back to back");

endmodule

bind parallel_copy_resolver_top pcr_check u_pcr_check (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for parallel_copy_resolver_top. Move beats are driven
// through the input handshake while a scoreboard class keeps its own copy of
// the move table and use counts, resolves each finished set into permutation
// moves, restore copies and an end marker, and checks every output beat in
// order. Runs a directed set of cases, then random move sets under several
// register counts and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import pcr_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [REG_W-1:0]  mv_from;
		logic [REG_W-1:0]  mv_to;
		logic [SLOT_W-1:0] slot;
		logic              closing;
	} move_t;

	class resolved_move_board;
		logic [CFG_W-1:0]        count_reg;
		logic [REG_W:0]          src_of [MAX_REGS_DEF];
		logic [CNT_W-1:0]        uses [MAX_REGS_DEF];
		logic [MAX_REGS_DEF-1:0] keep;
		bit                      moved;
		logic [7:0]              restores [MAX_REGS_DEF];
		int unsigned             n_restores;
		move_t                   due[$];
		int unsigned             errors, results, sets, perm_moves, restore_copies;

		function new();
			count_reg = REG_COUNT_RST;
			errors = 0;
			results = 0;
			sets = 0;
			perm_moves = 0;
			restore_copies = 0;
			clear_set();
		endfunction

		function void clear_set();
			for (int i = 0; i < MAX_REGS_DEF; i++) begin
				src_of[i] = (REG_W+1)'(MAX_REGS_DEF);
				uses[i] = '0;
				restores[i] = '0;
			end
			keep = '0;
			moved = 1'b0;
			n_restores = 0;
		endfunction

		function void set_count(logic [CFG_W-1:0] v);
			count_reg = v;
		endfunction

		function int unsigned active_regs();
			if (count_reg == 0)
				return 1;
			if (count_reg > MAX_REGS_DEF)
				return MAX_REGS_DEF;
			return count_reg;
		endfunction

		function int unsigned waiting();
			return due.size();
		endfunction

		function void bump(int unsigned r);
			if (uses[r] < COUNT_MAX)
				uses[r]++;
		endfunction

		function void push(logic [KIND_W-1:0] k, logic [REG_W-1:0] a, logic [REG_W-1:0] b,
				logic [SLOT_W-1:0] sl, logic c);
			move_t m;
			m.kind = k;
			m.mv_from = a;
			m.mv_to = b;
			m.slot = sl;
			m.closing = c;
			due.push_back(m);
			if (k == KIND_PERM)
				perm_moves++;
			if (k == KIND_RESTORE)
				restore_copies++;
		endfunction

		function void note_beat(logic [REG_W-1:0] d, logic [REG_W-1:0] s, logic live,
				logic fin);
			int unsigned n, t, r, slot;
			logic [REG_W:0] f;
			logic [7:0] rec;
			n = active_regs();
			if (d < n && s < n) begin
				src_of[d] = {1'b0, s};
				bump(s);
				if (d != s)
					moved = 1'b1;
				if (live) begin
					src_of[s] = {1'b0, s};
					keep[s] = 1'b1;
				end
			end
			if (!fin)
				return;
			sets++;
			if (moved) begin
				for (r = 0; r < n; r++)
					if (keep[r])
						bump(r);
				// keep one edge per source, cut the rest into restores
				for (t = 0; t < n; t++) begin
					f = src_of[t];
					if (f >= n)
						continue;
					if (f == t || uses[f] == 1) begin
						for (r = 0; r < n; r++) begin
							if (r != t && src_of[r] == f) begin
								if (n_restores < MAX_REGS_DEF) begin
									rec = 8'((t << 4) | r);
									restores[n_restores] = rec;
									n_restores++;
								end
								src_of[r] = (REG_W+1)'(MAX_REGS_DEF);
							end
						end
						uses[f] = CNT_W'(1);
					end else if (uses[f] != 0) begin
						uses[f]--;
					end
				end
				slot = 0;
				for (r = 0; r < n; r++) begin
					f = src_of[r];
					if (f >= n || f == r)
						continue;
					push(KIND_PERM, f[REG_W-1:0], REG_W'(r), SLOT_W'(slot), 1'b0);
					slot++;
				end
				for (r = 0; r < n_restores; r++)
					push(KIND_RESTORE, restores[r][7:4], restores[r][3:0], '0, 1'b0);
			end
			push(KIND_END, '0, '0, '0, 1'b1);
			clear_set();
		endfunction

		function void compare(string field, logic [3:0] want, logic [3:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		function void check_move(logic [KIND_W-1:0] k, logic [REG_W-1:0] a,
				logic [REG_W-1:0] b, logic [SLOT_W-1:0] sl, logic c);
			move_t exp_m;
			results++;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual kind %0d from %0d to %0d",
					$time, k, a, b);
				return;
			end
			exp_m = due.pop_front();
			compare("kind", exp_m.kind, k);
			compare("move_from", exp_m.mv_from, a);
			compare("move_to", exp_m.mv_to, b);
			compare("perm_slot", exp_m.slot, sl);
			compare("last_result", exp_m.closing, c);
		endfunction
	endclass

	localparam int SETTLE_CYCLES = 20;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [REG_W-1:0]    dest_reg = '0;
	logic [REG_W-1:0]    src_reg = '0;
	logic                src_live = 1'b0;
	logic                last_move = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [REG_W-1:0]    move_from;
	logic [REG_W-1:0]    move_to;
	logic [SLOT_W-1:0]   perm_slot;
	logic                last_result;

	int                  send_idle = 12;
	int                  recv_idle = 84;
	int unsigned         beats_sent = 0;
	resolved_move_board  sb = new();

	parallel_copy_resolver_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.dest_reg   (dest_reg),
		.src_reg    (src_reg),
		.src_live   (src_live),
		.last_move  (last_move),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.move_from  (move_from),
		.move_to    (move_to),
		.perm_slot  (perm_slot),
		.last_result(last_result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_move(kind, move_from, move_to, perm_slot, last_result);
	end

	task automatic send_beat(input logic [REG_W-1:0] d, input logic [REG_W-1:0] s,
			input logic live, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		dest_reg  <= d;
		src_reg   <= s;
		src_live  <= live;
		last_move <= fin;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(d, s, live, fin);
		beats_sent++;
	endtask

	// hold the sender off until every expected beat is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.waiting() != 0);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_count(v);
	endtask

	task automatic random_set();
		int unsigned n, k, i, j, tmp;
		int unsigned order [MAX_REGS_DEF];
		logic [REG_W-1:0] d, s;
		bit open_end;
		n = sb.active_regs();
		if ($urandom_range(99) < 15) begin
			send_beat(REG_W'($urandom_range(15)), REG_W'($urandom_range(15)),
				$urandom_range(1) == 1, $urandom_range(7) == 0);
			return;
		end
		for (i = 0; i < n; i++)
			order[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		k = ($urandom_range(3) == 0) ? $urandom_range(n, 1)
			: $urandom_range((n < 4) ? n : 4, 1);
		open_end = ($urandom_range(9) == 0);
		for (i = 0; i < k; i++) begin
			d = REG_W'(($urandom_range(9) == 0) ? order[$urandom_range(i)] : order[i]);
			s = REG_W'(($urandom_range(9) < 6) ? order[(i + 1) % k]
				: $urandom_range(n - 1));
			send_beat(d, s, $urandom_range(3) == 0, (i == k - 1) && !open_end);
		end
	endtask

	// one source fanned out far enough to saturate its use count
	task automatic hammer_set();
		int unsigned n, i;
		logic [REG_W-1:0] s;
		n = sb.active_regs();
		s = REG_W'($urandom_range(n - 1));
		for (i = 0; i < 34; i++)
			send_beat(REG_W'($urandom_range(n - 1)), s, i == 0, i == 33);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] count, input int s_idle,
			input int r_idle, input int unsigned quota);
		int unsigned stop_at;
		write_count(count);
		send_idle = s_idle;
		recv_idle = r_idle;
		stop_at = beats_sent + quota;
		while (beats_sent < stop_at) begin
			random_set();
			if ($urandom_range(7) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_count(REG_COUNT_RST);

		send_beat(4'd0, 4'd0, 1'b0, 1'b1);
		send_beat(4'd0, 4'd1, 1'b0, 1'b0);
		send_beat(4'd1, 4'd0, 1'b0, 1'b1);
		send_beat(4'd2, 4'd3, 1'b1, 1'b0);
		send_beat(4'd4, 4'd3, 1'b0, 1'b1);
		send_beat(4'd15, 4'd0, 1'b1, 1'b0);
		send_beat(4'd0, 4'd15, 1'b0, 1'b0);
		send_beat(4'd14, 4'd15, 1'b0, 1'b1);
		send_beat(4'd5, 4'd6, 1'b0, 1'b0);
		send_beat(4'd5, 4'd7, 1'b0, 1'b0);
		send_beat(4'd6, 4'd5, 1'b0, 1'b1);
		send_beat(4'd8, 4'd8, 1'b1, 1'b1);
		send_beat(4'd9, 4'd10, 1'b0, 1'b0);
		send_beat(4'd10, 4'd11, 1'b0, 1'b0);
		send_beat(4'd11, 4'd9, 1'b0, 1'b0);
		send_beat(4'd12, 4'd9, 1'b0, 1'b1);
		send_beat(4'd3, 4'd3, 1'b0, 1'b0);
		send_beat(4'd7, 4'd1, 1'b1, 1'b1);
		// left open across the count change below
		send_beat(4'd13, 4'd12, 1'b0, 1'b0);
		send_beat(4'd1, 4'd14, 1'b0, 1'b0);

		run_phase(5'd0, 12, 84, 8);
		run_phase(5'd31, 12, 84, 25);
		run_phase(CFG_W'($urandom_range(15, 2)), 84, 12, 25);
		run_phase(5'd1, 84, 12, 6);
		run_phase(REG_COUNT_RST, 0, 0, 25);
		hammer_set();
		run_phase(CFG_W'($urandom_range(16, 2)), 0, 0, 12);

		drain();
		repeat (40) @(posedge clk);
		$display("Resolved %0d move sets from %0d input beats across seven register counts,",
			sb.sets, beats_sent);
		$display("checking %0d output beats: %0d permutation moves, %0d restore copies.",
			sb.results, sb.perm_moves, sb.restore_copies);
		if (sb.errors == 0) begin
			$display("parallel_copy_resolver_top verification clean");
		end else begin
			$display("parallel_copy_resolver_top verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d output beats still due", sb.waiting());
		$display("parallel_copy_resolver_top verification failed");
		$finish;
	end

endmodule

/* parallel_copy_resolver_top.f */
rtl/core/pcr_pkg.sv
rtl/core/pcr_unit.sv
rtl/core/pcr_rbuf.sv
rtl/core/pcr_core.sv
rtl/core/parallel_copy_resolver_top.sv
rtl/core/pcr_check.sv
test/tb_top.sv
